// ----- rtl/core/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int WORD_W     = 64;   // internal fixed-point word
    localparam int IN_W       = 32;   // input point width
    localparam int IN_FRAC    = 28;   // fraction bits of the input point
    localparam int HALF_W     = 32;   // operand width of one partial product
    localparam int ACC_W      = 128;  // full product width
    localparam int LIMIT_W    = 20;
    localparam int CNT_W      = LIMIT_W + 1;
    localparam int ESCAPE_INT = 16;   // escape radius squared

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
    localparam logic [1:0]         STEP_LAST   = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MAX     = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_NEG_MAX = {1'b1, {(WORD_W-2){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_MUL,
        ST_FIX,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       mag_en;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       fix_en;
        logic       update_en;
    } dp_cmd_t;

    typedef struct packed {
        logic escaped;
        logic over_limit;
    } dp_status_t;

endpackage

// ----- rtl/core/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one complex point c given in signed Q4.28.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. One iteration of
// z = z^2 + c runs through a magnitude load, four 32x32 partial-product
// steps shared by the three squares/products, one scaling step and one update
// and exit-test step; iterations repeat until the point escapes or reaches
// iteration_limit (100 at reset). The result is on iteration_count and
// hit_limit for the single cycle in which done is high and must be taken
// then, since the receiver cannot stall the block; a new request may be given
// in that same cycle. iteration_limit is written over the cfg channel (always
// ready); the user must write it only while the block is idle, since the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] point_real,
    input  logic signed [IN_W-1:0] point_imag,
    output logic                   done,
    output logic [LIMIT_W-1:0]     iteration_count,
    output logic                   hit_limit,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    dp_cmd_t            cmd;
    dp_status_t         status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    mbe_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mbe_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath
    (
        .clk             (clk),
        .cmd             (cmd),
        .point_real      (point_real),
        .point_imag      (point_imag),
        .limit           (limit_reg),
        .status          (status),
        .iteration_count (iteration_count),
        .hit_limit       (hit_limit)
    );

endmodule

// ----- rtl/core/mbe_fixmul.sv -----
// ----------------------------------------------------------------------------
// mbe_fixmul
// Signed fixed-point multiplier: 64x64 magnitude product built from four
// 32x32 partial products, then scaled, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module mbe_fixmul
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                     clk,
    input  logic                     mag_en,
    input  logic                     mul_en,
    input  logic [1:0]               mul_step,
    input  logic                     fix_en,
    input  logic signed [WORD_W-1:0] a,
    input  logic signed [WORD_W-1:0] b,
    output logic signed [WORD_W-1:0] prod
);

    logic [WORD_W-1:0] mag_a_reg, mag_b_reg;
    logic [WORD_W-1:0] mag_a_next, mag_b_next;
    logic              neg_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [WORD_W-1:0] prod_reg, prod_next;

    logic [WORD_W-1:0] a_u, b_u;
    logic [HALF_W-1:0] op_a, op_b;
    logic [WORD_W-1:0] pp;
    logic [ACC_W-1:0]  pp_shift;
    logic [ACC_W-1:0]  scaled;
    logic              ovf;
    logic [WORD_W-1:0] mag_r;

    assign a_u        = a;
    assign b_u        = b;
    assign mag_a_next = a_u[WORD_W-1] ? (~a_u + WORD_W'(1)) : a_u;
    assign mag_b_next = b_u[WORD_W-1] ? (~b_u + WORD_W'(1)) : b_u;

    // step bit 1 picks the high half of a, bit 0 the high half of b
    assign op_a = mul_step[1] ? mag_a_reg[WORD_W-1:HALF_W] : mag_a_reg[HALF_W-1:0];
    assign op_b = mul_step[0] ? mag_b_reg[WORD_W-1:HALF_W] : mag_b_reg[HALF_W-1:0];
    assign pp   = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};

    always_comb
    begin
        case (mul_step) inside
            2'd0:       pp_shift = {{WORD_W{1'b0}}, pp};
            2'd1, 2'd2: pp_shift = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
            default:    pp_shift = {pp, {WORD_W{1'b0}}};
        endcase
    end

    assign acc_next = (mul_step == 2'd0) ? pp_shift : (acc_reg + pp_shift);

    // drop the fraction, saturate if anything lands at or above bit 63
    assign scaled    = acc_reg >> FRAC_BITS;
    assign ovf       = |scaled[ACC_W-1:WORD_W-1];
    assign mag_r     = ovf ? WORD_MAX : {1'b0, scaled[WORD_W-2:0]};
    assign prod_next = neg_reg ? (~mag_r + WORD_W'(1)) : mag_r;

    always_ff @(posedge clk)
    begin
        if (mag_en)
        begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            neg_reg   <= a_u[WORD_W-1] ^ b_u[WORD_W-1];
        end
        if (mul_en)
        begin
            acc_reg <= acc_next;
        end
        if (fix_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = $signed(prod_reg);

endmodule

// ----- rtl/core/mbe_datapath.sv -----
// ----------------------------------------------------------------------------
// mbe_datapath
// Point registers, z iteration update, escape and limit tests, result
// registers. Three fixed-point multipliers form x*x, y*y and x*y together.
// ----------------------------------------------------------------------------
module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                     clk,
    input  dp_cmd_t                  cmd,
    input  logic signed [IN_W-1:0]   point_real,
    input  logic signed [IN_W-1:0]   point_imag,
    input  logic [LIMIT_W-1:0]       limit,
    output dp_status_t               status,
    output logic [LIMIT_W-1:0]       iteration_count,
    output logic                     hit_limit
);

    localparam int SHL = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
    localparam int SHR = (FRAC_BITS >= IN_FRAC) ? 0 : (IN_FRAC - FRAC_BITS);
    localparam logic signed [WORD_W-1:0] ESCAPE = $signed(WORD_W'(ESCAPE_INT) << FRAC_BITS);

    function automatic logic signed [WORD_W-1:0] sat_add(
        input logic signed [WORD_W-1:0] p,
        input logic signed [WORD_W-1:0] q
    );
        logic signed [WORD_W:0] s;
        s = {p[WORD_W-1], p} + {q[WORD_W-1], q};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? $signed(WORD_NEG_MAX) : $signed(WORD_MAX);
        return s[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sub(
        input logic signed [WORD_W-1:0] p,
        input logic signed [WORD_W-1:0] q
    );
        logic signed [WORD_W:0] s;
        s = {p[WORD_W-1], p} - {q[WORD_W-1], q};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? $signed(WORD_NEG_MAX) : $signed(WORD_MAX);
        return s[WORD_W-1:0];
    endfunction

    logic signed [WORD_W-1:0] cx_reg, cy_reg, x_reg, y_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [LIMIT_W-1:0]       iteration_count_reg;
    logic                     hit_limit_reg;

    logic signed [WORD_W-1:0] re_ext, im_ext, cx_next, cy_next;
    logic signed [WORD_W-1:0] xx, yy, xy;
    logic signed [WORD_W-1:0] sum_sq, x_next, y_next;
    logic [CNT_W-1:0]         count_next;
    logic                     escaped, over_limit;

    // q4.28 to internal format, floor when fraction bits are dropped
    assign re_ext  = $signed({{(WORD_W-IN_W){point_real[IN_W-1]}}, point_real});
    assign im_ext  = $signed({{(WORD_W-IN_W){point_imag[IN_W-1]}}, point_imag});
    assign cx_next = (re_ext <<< SHL) >>> SHR;
    assign cy_next = (im_ext <<< SHL) >>> SHR;

    mbe_fixmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx
    (
        .clk      (clk),
        .mag_en   (cmd.mag_en),
        .mul_en   (cmd.mul_en),
        .mul_step (cmd.mul_step),
        .fix_en   (cmd.fix_en),
        .a        (x_reg),
        .b        (x_reg),
        .prod     (xx)
    );

    mbe_fixmul #(.FRAC_BITS(FRAC_BITS)) u_mul_yy
    (
        .clk      (clk),
        .mag_en   (cmd.mag_en),
        .mul_en   (cmd.mul_en),
        .mul_step (cmd.mul_step),
        .fix_en   (cmd.fix_en),
        .a        (y_reg),
        .b        (y_reg),
        .prod     (yy)
    );

    mbe_fixmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy
    (
        .clk      (clk),
        .mag_en   (cmd.mag_en),
        .mul_en   (cmd.mul_en),
        .mul_step (cmd.mul_step),
        .fix_en   (cmd.fix_en),
        .a        (x_reg),
        .b        (y_reg),
        .prod     (xy)
    );

    assign sum_sq     = sat_add(xx, yy);
    assign escaped    = sum_sq > ESCAPE;
    assign x_next     = sat_add(sat_sub(xx, yy), cx_reg);
    assign y_next     = sat_add(sat_add(xy, xy), cy_reg);
    assign count_next = count_reg + CNT_W'(1);
    assign over_limit = count_next > {1'b0, limit};

    assign status.escaped    = escaped;
    assign status.over_limit = over_limit;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
        end
        else if (cmd.update_en)
        begin
            if (escaped)
            begin
                iteration_count_reg <= count_reg[LIMIT_W-1:0];
                hit_limit_reg       <= 1'b0;
            end
            else
            begin
                x_reg     <= x_next;
                y_reg     <= y_next;
                count_reg <= count_next;
                if (over_limit)
                begin
                    iteration_count_reg <= limit;
                    hit_limit_reg       <= 1'b1;
                end
            end
        end
    end

    assign iteration_count = iteration_count_reg;
    assign hit_limit       = hit_limit_reg;

endmodule

// ----- rtl/core/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbe_ctrl
// Iteration sequencer: magnitude load, four partial-product steps, scaling,
// then update and exit test, repeated until escape or limit.
// ----------------------------------------------------------------------------
module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       done_reg, done_next;
    logic       finish;

    assign finish = status.escaped || status.over_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_MAG;
            end
            ST_MAG:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_LAST)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = finish ? ST_IDLE : ST_MAG;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mul_step = step_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd.load   = start;
            ST_MAG:    cmd.mag_en = 1'b1;
            ST_MUL:    cmd.mul_en = 1'b1;
            ST_FIX:    cmd.fix_en = 1'b1;
            ST_UPDATE:
            begin
                cmd.update_en = 1'b1;
                done_next     = finish;
            end
            default:   cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_UPDATE)
        else $error("result strobe without an update step");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_MUL |-> step_reg == 2'd0)
        else $error("partial-product step not cleared");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mag_en, cmd.mul_en, cmd.fix_en, cmd.update_en}))
        else $error("overlapping datapath commands");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives complex points into mandelbrot_escape_time and compares each
// iteration_count / hit_limit result against an in-bench fixed-point model
// of the escape-time loop, over several iteration_limit settings.
// ----------------------------------------------------------------------------
module testbench;
    import mbe_pkg::*;

    localparam int FRAC = 28;

    typedef struct packed {
        logic [LIMIT_W-1:0] count;
        logic               capped;
    } escape_result_t;

    class escape_scoreboard;
        localparam logic [63:0] POS_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
        localparam logic [63:0] NEG_SAT = 64'h8000_0000_0000_0001;

        int                 frac_bits;
        int                 err_count;
        logic [LIMIT_W-1:0] limit;
        escape_result_t     pending_escapes[$];

        function new(int frac);
            frac_bits = frac;
            err_count = 0;
            limit     = LIMIT_W'(100);
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return pending_escapes.size();
        endfunction

        // 65-bit intermediate, clipped to +-(2^63 - 1)
        function logic signed [63:0] clamp(logic [64:0] v);
            if (v[64] != v[63])
                return v[64] ? NEG_SAT : POS_SAT;
            return v[63:0];
        endfunction

        function logic signed [63:0] sum(logic signed [63:0] a, logic signed [63:0] b);
            return clamp({a[63], a} + {b[63], b});
        endfunction

        function logic signed [63:0] diff(logic signed [63:0] a, logic signed [63:0] b);
            return clamp({a[63], a} - {b[63], b});
        endfunction

        // full product of the magnitudes, scaled down, truncated toward zero
        function logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                    logic signed [63:0] b);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] p;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            p = ({64'b0, ma} * {64'b0, mb}) >> frac_bits;
            if (p > {64'b0, POS_SAT})
                p = {64'b0, POS_SAT};
            return (a[63] ^ b[63]) ? -p[63:0] : p[63:0];
        endfunction

        function logic signed [63:0] widen(logic signed [IN_W-1:0] v);
            logic signed [63:0] w;
            w = v;
            if (frac_bits >= IN_FRAC)
                return w <<< (frac_bits - IN_FRAC);
            return w >>> (IN_FRAC - frac_bits);
        endfunction

        function escape_result_t escape_time(logic signed [IN_W-1:0] re,
                                             logic signed [IN_W-1:0] im);
            logic signed [63:0] cx;
            logic signed [63:0] cy;
            logic signed [63:0] x;
            logic signed [63:0] y;
            logic signed [63:0] xx;
            logic signed [63:0] yy;
            logic signed [63:0] xy;
            logic signed [63:0] radius;
            int unsigned        n;
            bit                 settled;
            escape_result_t     r;
            cx      = widen(re);
            cy      = widen(im);
            x       = '0;
            y       = '0;
            n       = 0;
            settled = 1'b0;
            r       = '0;
            radius  = 64'sd16 <<< frac_bits;
            while (!settled)
            begin
                xx = scaled_product(x, x);
                yy = scaled_product(y, y);
                if (sum(xx, yy) > radius)
                begin
                    r       = '{n[LIMIT_W-1:0], 1'b0};
                    settled = 1'b1;
                end
                else
                begin
                    xy = scaled_product(x, y);
                    x  = sum(diff(xx, yy), cx);
                    y  = sum(sum(xy, xy), cy);
                    n++;
                    if (n > limit)
                    begin
                        r       = '{limit, 1'b1};
                        settled = 1'b1;
                    end
                end
            end
            return r;
        endfunction

        function void note_point(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im);
            pending_escapes.push_back(escape_time(re, im));
        endfunction

        function void check_result(logic [LIMIT_W-1:0] count, logic capped);
            escape_result_t want;
            if (pending_escapes.size() == 0)
            begin
                $error("unexpected result: iteration_count=%0d hit_limit=%0b", count, capped);
                err_count++;
                return;
            end
            want = pending_escapes.pop_front();
            if (count !== want.count)
            begin
                $error("iteration_count: expected %0d, got %0d", want.count, count);
                err_count++;
            end
            if (capped !== want.capped)
            begin
                $error("hit_limit: expected %0b, got %0b", want.capped, capped);
                err_count++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [IN_W-1:0] point_real;
    logic signed [IN_W-1:0] point_imag;
    logic                   done;
    logic [LIMIT_W-1:0]     iteration_count;
    logic                   hit_limit;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     cfg_data;

    escape_scoreboard board = new(FRAC);
    int               points_sent = 0;

    mandelbrot_escape_time #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .point_real      (point_real),
        .point_imag      (point_imag),
        .done            (done),
        .iteration_count (iteration_count),
        .hit_limit       (hit_limit),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done)
            board.check_result(iteration_count, hit_limit);
    end

    task automatic send_point(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im);
        @(negedge clk);
        start      <= 1'b1;
        point_real <= re;
        point_imag <= im;
        do
            @(posedge clk);
        while (busy);
        board.note_point(re, im);
        points_sent++;
    endtask

    task automatic idle_for(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // hold requests until every outstanding result is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (board.pending() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_iteration_limit(logic [LIMIT_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_limit(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // escape_only keeps |re| at or above 2.5 so the orbit leaves within a few steps
    function automatic void pick_point(bit escape_only,
                                       output logic signed [IN_W-1:0] re,
                                       output logic signed [IN_W-1:0] im);
        logic [IN_W-1:0] mag;
        if (escape_only)
        begin
            mag = $urandom_range(32'h7FFF_FFFF, 32'h2800_0000);
            re  = $urandom_range(1) ? -mag : mag;
            im  = $urandom;
        end
        else if ($urandom_range(9) < 3)
        begin
            re = $urandom;
            im = $urandom;
        end
        else
        begin
            // window [-2.25, 0.75] x [-1.5, 1.5] around the set
            re = $urandom_range(32'h3000_0000) - 32'h2400_0000;
            im = $urandom_range(32'h3000_0000) - 32'h1800_0000;
        end
    endfunction

    task automatic run_phase(int count, bit escape_only);
        int                     burst;
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
        burst = $urandom_range(30, 1);
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                idle_for($urandom_range(25, 1));
                burst = $urandom_range(30, 1);
            end
            pick_point(escape_only, re, im);
            send_point(re, im);
            burst--;
        end
    endtask

    initial
    begin
        #(100_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        point_real = '0;
        point_imag = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // corners and known orbits at the reset limit
        send_point(32'sh0000_0000, 32'sh0000_0000);     // origin, inside
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh8000_0000);
        send_point(32'sh0000_0001, 32'shFFFF_FFFF);     // one lsb each way
        send_point(32'shE000_0000, 32'sh0000_0000);     // -2, tip of the set
        send_point(32'sh0400_0000, 32'sh0000_0000);     // 0.25, cusp
        send_point(32'sh0428_F5C3, 32'sh0000_0000);     // just past the cusp, slow
        send_point(32'sh4000_0000, 32'sh0000_0000);     // |z|^2 lands exactly on 16
        send_point(32'sh0000_0000, 32'sh4000_0000);
        send_point(32'shC000_0000, 32'sh0000_0000);
        send_point(32'sh2000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh1000_0000);     // i, periodic orbit
        send_point(32'shF000_0000, 32'sh0000_0000);     // -1, period two
        send_point(32'shF400_0000, 32'sh0199_999A);     // near the neck
        send_point(32'shE400_0000, 32'shFF00_0000);

        // limit of zero caps every point at the first step
        set_iteration_limit('0);
        run_phase(60, 1'b0);
        set_iteration_limit('1);
        run_phase(40, 1'b1);
        set_iteration_limit(LIMIT_W'(1));
        run_phase(60, 1'b0);
        set_iteration_limit(LIMIT_W'(1000000));
        run_phase(40, 1'b1);
        while (points_sent < 2000)
        begin
            set_iteration_limit(LIMIT_W'($urandom_range(120, 2)));
            run_phase($urandom_range(250, 100), 1'b0);
        end

        drain();
        repeat (30) @(posedge clk);
        if (board.err_count == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mbe_pkg.sv
rtl/core/mbe_fixmul.sv
rtl/core/mbe_datapath.sv
rtl/core/mbe_ctrl.sv
rtl/core/mandelbrot_escape_time.sv
tb/testbench.sv
